/* hdl/utk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package utk_pkg;

    localparam int SLOTS = 3;

    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_QUERY = 8'h3F;  // '?'
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SCHEME = 3'd1,
        PH_HOST   = 3'd2,
        PH_PORT   = 3'd3,
        PH_PATH   = 3'd4,
        PH_PARAM  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        PART_SCHEME = 3'd0,
        PART_HOST   = 3'd1,
        PART_PORT   = 3'd2,
        PART_PATH   = 3'd3,
        PART_PNAME  = 3'd4,
        PART_PVALUE = 3'd5,
        PART_DELIM  = 3'd6
    } part_t;

    typedef enum logic [1:0] {
        FAULT_OK     = 2'd0,
        FAULT_EMPTY  = 2'd1,
        FAULT_NO_SEP = 2'd2
    } fault_t;

    typedef struct packed {
        logic [7:0] out_byte;
        part_t      part;
        logic       param_begins;
        logic       url_done;
        fault_t     fault;
        logic       has_byte;
    } result_t;

    typedef struct packed {
        result_t [SLOTS-1:0] slot;
        logic [1:0]          cnt;
    } bundle_t;

    typedef struct packed {
        logic    load;
        bundle_t bundle;
    } load_t;

endpackage

`default_nettype wire

/* hdl/utk_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface utk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] url_byte;
    logic       end_only;
    logic       final_byte;

    modport source (output valid, output url_byte, output end_only, output final_byte,
                    input ready);
    modport sink   (input valid, input url_byte, input end_only, input final_byte,
                    output ready);
endinterface

interface utk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] part;
    logic       param_begins;
    logic       url_done;
    logic [1:0] fault;
    logic       has_byte;

    modport source (output valid, output out_byte, output part, output param_begins,
                    output url_done, output fault, output has_byte, input ready);
    modport sink   (input valid, input out_byte, input part, input param_begins,
                    input url_done, input fault, input has_byte, output ready);
endinterface

`default_nettype wire

/* hdl/url_byte_tokenizer_top.sv */
// channel   dir  payload                                              handshake
// tok_in    in   url_byte[8] end_only final_byte                      valid/ready
// tok_out   out  out_byte[8] part[3] param_begins url_done fault[2]   valid/ready
//                has_byte
//
// Each input transaction yields zero to three results, which leave one per cycle
// from a three-slot result buffer unless tok_out stalls. An input is taken while the
// last buffered result leaves, so bytes that make one result each flow at full rate.
// Zero-result inputs (held ':' or ":/") produce no output.
// Reset (rst_n, async, low) returns to start of URL and empties the buffer.
// A stall on tok_out holds the buffer and deasserts tok_in.ready.
`timescale 1ns / 1ps
`default_nettype none

module url_byte_tokenizer_top
    import utk_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    utk_in_if.sink     tok_in,
    utk_out_if.source  tok_out
);

    load_t ld;
    logic  take;

    utk_classify u_classify (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (tok_in),
        .take  (take),
        .ld    (ld)
    );

    utk_serialize u_serialize (
        .clk    (clk),
        .rst_n  (rst_n),
        .ld     (ld),
        .take   (take),
        .out_ch (tok_out)
    );

endmodule

`default_nettype wire

/* hdl/utk_classify.sv */
`timescale 1ns / 1ps
`default_nettype none

module utk_classify
    import utk_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    utk_in_if.sink    in_ch,
    input  wire logic take,
    output load_t     ld
);

    phase_t phase_reg, phase_next;
    logic   hv0_reg, hv0_next;   // ':' held
    logic   hv1_reg, hv1_next;   // ":/" held
    logic   pf_reg, pf_next;     // next parameter byte opens a parameter
    logic   vs_reg, vs_next;     // '=' seen in this parameter

    logic    accept;
    bundle_t bnd;

    function automatic result_t mk(input logic [7:0] b, input part_t p, input logic pb);
        result_t r;
        r.out_byte     = b;
        r.part         = p;
        r.param_begins = pb;
        r.url_done     = 1'b0;
        r.fault        = FAULT_OK;
        r.has_byte     = 1'b1;
        return r;
    endfunction

    assign in_ch.ready = take;
    assign accept      = in_ch.valid && take;

    always_comb
    begin
        logic [7:0] b;
        logic       fresh;
        logic       pb;
        fault_t     flt;

        b          = in_ch.url_byte;
        fresh      = 1'b0;
        pb         = 1'b0;
        flt        = FAULT_OK;
        phase_next = phase_reg;
        hv0_next   = hv0_reg;
        hv1_next   = hv1_reg;
        pf_next    = pf_reg;
        vs_next    = vs_reg;
        bnd        = '0;

        if (!in_ch.end_only)
        begin
            unique case (phase_reg)
                PH_START, PH_SCHEME:
                begin
                    if (phase_reg == PH_START && b == CH_SLASH)
                    begin
                        phase_next = PH_PATH;
                        bnd.slot[bnd.cnt] = mk(b, PART_PATH, 1'b0);
                        bnd.cnt = bnd.cnt + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_SCHEME;
                        if (hv1_reg)
                        begin
                            hv0_next = 1'b0;
                            hv1_next = 1'b0;
                            if (b == CH_SLASH)
                            begin
                                bnd.slot[0] = mk(CH_COLON, PART_DELIM, 1'b0);
                                bnd.slot[1] = mk(CH_SLASH, PART_DELIM, 1'b0);
                                bnd.slot[2] = mk(b, PART_DELIM, 1'b0);
                                bnd.cnt     = 2'd3;
                                phase_next  = PH_HOST;
                            end
                            else
                            begin
                                bnd.slot[0] = mk(CH_COLON, PART_SCHEME, 1'b0);
                                bnd.slot[1] = mk(CH_SLASH, PART_SCHEME, 1'b0);
                                bnd.cnt     = 2'd2;
                                fresh       = 1'b1;
                            end
                        end
                        else if (hv0_reg)
                        begin
                            if (b == CH_SLASH)
                            begin
                                hv1_next = 1'b1;
                            end
                            else
                            begin
                                bnd.slot[0] = mk(CH_COLON, PART_SCHEME, 1'b0);
                                bnd.cnt     = 2'd1;
                                hv0_next    = 1'b0;
                                fresh       = 1'b1;
                            end
                        end
                        else
                        begin
                            fresh = 1'b1;
                        end

                        if (fresh)
                        begin
                            if (b == CH_COLON)
                            begin
                                hv0_next = 1'b1;
                            end
                            else
                            begin
                                bnd.slot[bnd.cnt] = mk(b, PART_SCHEME, 1'b0);
                                bnd.cnt = bnd.cnt + 2'd1;
                            end
                        end
                    end
                end
                PH_HOST:
                begin
                    bnd.cnt = 2'd1;
                    if (b == CH_SLASH)
                    begin
                        phase_next  = PH_PATH;
                        bnd.slot[0] = mk(b, PART_PATH, 1'b0);
                    end
                    else if (b == CH_COLON)
                    begin
                        phase_next  = PH_PORT;
                        bnd.slot[0] = mk(b, PART_DELIM, 1'b0);
                    end
                    else
                    begin
                        bnd.slot[0] = mk(b, PART_HOST, 1'b0);
                    end
                end
                PH_PORT:
                begin
                    bnd.cnt = 2'd1;
                    if (b == CH_SLASH)
                    begin
                        phase_next  = PH_PATH;
                        bnd.slot[0] = mk(b, PART_PATH, 1'b0);
                    end
                    else
                    begin
                        bnd.slot[0] = mk(b, PART_PORT, 1'b0);
                    end
                end
                PH_PATH:
                begin
                    bnd.cnt = 2'd1;
                    if (b == CH_QUERY)
                    begin
                        phase_next  = PH_PARAM;
                        pf_next     = 1'b1;
                        vs_next     = 1'b0;
                        bnd.slot[0] = mk(b, PART_DELIM, 1'b0);
                    end
                    else
                    begin
                        bnd.slot[0] = mk(b, PART_PATH, 1'b0);
                    end
                end
                default:
                begin
                    bnd.cnt = 2'd1;
                    if (b == CH_AMP)
                    begin
                        pf_next     = 1'b1;
                        vs_next     = 1'b0;
                        bnd.slot[0] = mk(b, PART_DELIM, 1'b0);
                    end
                    else
                    begin
                        pb      = pf_reg;
                        pf_next = 1'b0;
                        if (!vs_reg && b == CH_EQ)
                        begin
                            vs_next     = 1'b1;
                            bnd.slot[0] = mk(b, PART_DELIM, pb);
                        end
                        else
                        begin
                            bnd.slot[0] = mk(b, vs_reg ? PART_PVALUE : PART_PNAME, pb);
                        end
                    end
                end
            endcase
        end

        if (in_ch.end_only || in_ch.final_byte)
        begin
            priority if (phase_next == PH_START)
                flt = FAULT_EMPTY;
            else if (phase_next == PH_SCHEME)
                flt = FAULT_NO_SEP;
            else
                flt = FAULT_OK;

            // release anything still held as plain scheme
            if (hv0_next)
            begin
                bnd.slot[bnd.cnt] = mk(CH_COLON, PART_SCHEME, 1'b0);
                bnd.cnt = bnd.cnt + 2'd1;
            end
            if (hv1_next)
            begin
                bnd.slot[bnd.cnt] = mk(CH_SLASH, PART_SCHEME, 1'b0);
                bnd.cnt = bnd.cnt + 2'd1;
            end
            if (in_ch.end_only || bnd.cnt == 2'd0)
            begin
                bnd.slot[bnd.cnt] = mk(8'h00, PART_SCHEME, 1'b0);
                bnd.slot[bnd.cnt].has_byte = 1'b0;
                bnd.cnt = bnd.cnt + 2'd1;
            end
            bnd.slot[bnd.cnt - 2'd1].url_done = 1'b1;
            bnd.slot[bnd.cnt - 2'd1].fault    = flt;

            phase_next = PH_START;
            hv0_next   = 1'b0;
            hv1_next   = 1'b0;
            pf_next    = 1'b0;
            vs_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            hv0_reg   <= 1'b0;
            hv1_reg   <= 1'b0;
            pf_reg    <= 1'b0;
            vs_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hv0_reg   <= hv0_next;
            hv1_reg   <= hv1_next;
            pf_reg    <= pf_next;
            vs_reg    <= vs_next;
        end
    end

    assign ld.load   = accept;
    assign ld.bundle = bnd;

    // a URL end always yields at least its closing result
    a_end_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.end_only || in_ch.final_byte) |-> bnd.cnt != 2'd0)
        else $error("URL end produced no result");

    // ":/" is only ever held on top of a held ':'
    a_hold_order: assert property (@(posedge clk) disable iff (!rst_n)
        hv1_reg |-> hv0_reg && phase_reg == PH_SCHEME)
        else $error("held slash without held colon");

    // an end returns the splitter to the start of a URL
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.end_only || in_ch.final_byte) |=> phase_reg == PH_START && !hv0_reg)
        else $error("state not cleared after URL end");

endmodule

`default_nettype wire

/* hdl/utk_serialize.sv */
`timescale 1ns / 1ps
`default_nettype none

module utk_serialize
    import utk_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire load_t ld,
    output logic       take,
    utk_out_if.source  out_ch
);

    result_t [SLOTS-1:0] slot_reg, slot_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [1:0]          idx_reg, idx_next;

    logic    fire;
    logic    last;
    result_t cur;

    assign cur  = slot_reg[idx_reg];
    assign fire = out_ch.valid && out_ch.ready;
    assign last = idx_reg == cnt_reg - 2'd1;
    assign take = (cnt_reg == 2'd0) || (fire && last);

    assign out_ch.valid        = cnt_reg != 2'd0;
    assign out_ch.out_byte     = cur.out_byte;
    assign out_ch.part         = cur.part;
    assign out_ch.param_begins = cur.param_begins;
    assign out_ch.url_done     = cur.url_done;
    assign out_ch.fault        = cur.fault;
    assign out_ch.has_byte     = cur.has_byte;

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        if (ld.load)
        begin
            // reload as the last transaction leaves, or into an empty buffer
            slot_next = ld.bundle.slot;
            cnt_next  = ld.bundle.cnt;
            idx_next  = 2'd0;
        end
        else if (fire)
        begin
            if (last)
            begin
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> idx_reg < cnt_reg)
        else $error("slot index beyond loaded count");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.url_done |-> last)
        else $error("URL end flagged before last slot");

    a_status_only_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (!out_ch.has_byte || out_ch.fault != FAULT_OK) |-> out_ch.url_done)
        else $error("status or fault on a non-final result");

endmodule

`default_nettype wire
